### src/exponential_search_sorted_store_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key store
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_SEARCH_SORTED_STORE_UNIT_ASSERT_SVH
`define EXPONENTIAL_SEARCH_SORTED_STORE_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define ESSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted store check failed");

// Check a consequent in the cycle after its antecedent
`define ESSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted store check failed");

`endif

### src/esss_pkg.sv
// ----------------------------------------------------------------------------
// esss_pkg
// Shared widths, request codes and sequencer states of the sorted key store.
// ----------------------------------------------------------------------------
package esss_pkg;

  // Fixed payload widths
  localparam int unsigned KeyInW = 32;
  localparam int unsigned MatchW = 10;

  // Request codes
  localparam logic ReqAppend = 1'b0;
  localparam logic ReqSearch = 1'b1;

  // Search sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StGallop,
    StGallopCmp,
    StBin,
    StBinCmp,
    StFinal,
    StFinalCmp,
    StResult
  } state_e;

endpackage

### src/esss_if.sv
// ----------------------------------------------------------------------------
// esss_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface esss_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [esss_pkg::KeyInW-1:0]  key_value;
  logic                                first_element;

  modport source (output valid, req_type, key_value, first_element, input ready);
  modport sink   (input valid, req_type, key_value, first_element, output ready);
endinterface

interface esss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [esss_pkg::MatchW-1:0]   match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

### src/exponential_search_sorted_store_unit.sv
// ----------------------------------------------------------------------------
// exponential_search_sorted_store_unit
// Ascending key store with a galloping lower-bound search over one RAM port.
// ----------------------------------------------------------------------------
//  Channel  Dir  Words                   Result
//  req_i    in   append or search key    search: one word on rsp_o
//  rsp_o    out  found, match_index      -
//
//  An append is written from the idle state. A search runs G gallop probes,
//  then B halving steps, then a final probe at the lower bound if it is in range.
//  Every probe is a registered read of the single key RAM read port then a compare.
//  req_i.ready is high only while the sequencer is idle; a finished result
//  waits in the response register and holds the next search at the end.
//  Reset clears the element count; the key RAM is not cleared.
// ----------------------------------------------------------------------------
`include "exponential_search_sorted_store_unit_assert.svh"

module exponential_search_sorted_store_unit #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  esss_req_if.sink          req_i,
  esss_rsp_if.source        rsp_o
);

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam logic [CntW-1:0]      Depth   = CntW'(STORE_DEPTH);
  localparam logic [KEY_WIDTH-1:0] SignBit = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // Key RAM, stored offset-binary so an unsigned compare orders signed keys
  logic [KEY_WIDTH-1:0] mem [STORE_DEPTH];

  esss_pkg::state_e state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [KEY_WIDTH-1:0] query_q, query_d;
  logic [KEY_WIDTH-1:0] rd_data_q;
  logic                 res_found_q, res_found_d;
  logic [CntW-1:0]      res_index_q, res_index_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q;
  logic [esss_pkg::MatchW-1:0] out_index_q;

  logic                 req_fire, out_free, out_load;
  logic                 wr_en, rd_en;
  logic [IdxW-1:0]      wr_addr, rd_addr;
  logic [KEY_WIDTH-1:0] key_biased;
  logic [CntW:0]        hi_grow;
  logic [CntW-1:0]      mid_calc;
  logic                 data_lt;

  assign req_fire   = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign key_biased = KEY_WIDTH'(req_i.key_value) ^ SignBit;
  assign hi_grow    = {hi_q, 1'b1};
  assign mid_calc   = lo_q + ((hi_q - lo_q) >> 1);
  assign data_lt    = rd_data_q < query_q;

  assign req_i.ready       = (state_q == esss_pkg::StIdle);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.match_index = out_index_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      esss_pkg::StIdle: begin
        if (req_fire && req_i.req_type == esss_pkg::ReqSearch) state_d = esss_pkg::StGallop;
      end
      esss_pkg::StGallop: begin
        state_d = (hi_q < count_q) ? esss_pkg::StGallopCmp : esss_pkg::StBin;
      end
      esss_pkg::StGallopCmp: begin
        state_d = data_lt ? esss_pkg::StGallop : esss_pkg::StBin;
      end
      esss_pkg::StBin: begin
        state_d = (lo_q < hi_q) ? esss_pkg::StBinCmp : esss_pkg::StFinal;
      end
      esss_pkg::StBinCmp:   state_d = esss_pkg::StBin;
      esss_pkg::StFinal: begin
        state_d = (lo_q < count_q) ? esss_pkg::StFinalCmp : esss_pkg::StResult;
      end
      esss_pkg::StFinalCmp: state_d = esss_pkg::StResult;
      esss_pkg::StResult: begin
        if (out_free) state_d = esss_pkg::StIdle;
      end
      default:              state_d = esss_pkg::StIdle;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    query_d     = query_q;
    res_found_d = res_found_q;
    res_index_d = res_index_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IdxW-1:0];
    rd_en       = 1'b0;
    rd_addr     = lo_q[IdxW-1:0];
    out_load    = 1'b0;
    unique case (state_q)
      esss_pkg::StIdle: begin
        if (req_fire) begin
          if (req_i.req_type == esss_pkg::ReqAppend) begin
            // restart at index zero, or append while room is left
            if (req_i.first_element) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              count_d = CntW'(1);
            end else if (count_q < Depth) begin
              wr_en   = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else begin
            query_d = key_biased;
            lo_d    = '0;
            hi_d    = (count_q == '0) ? '0 : CntW'(1);
          end
        end
      end
      esss_pkg::StGallop: begin
        rd_en   = hi_q < count_q;
        rd_addr = hi_q[IdxW-1:0];
      end
      esss_pkg::StGallopCmp: begin
        // widen the bracket while the probed key is still below the query
        if (data_lt) begin
          lo_d = hi_q + CntW'(1);
          hi_d = (hi_grow < {1'b0, count_q}) ? hi_grow[CntW-1:0] : count_q;
        end
      end
      esss_pkg::StBin: begin
        mid_d   = mid_calc;
        rd_en   = lo_q < hi_q;
        rd_addr = mid_calc[IdxW-1:0];
      end
      esss_pkg::StBinCmp: begin
        if (data_lt) lo_d = mid_q + CntW'(1);
        else         hi_d = mid_q;
      end
      esss_pkg::StFinal: begin
        rd_en       = lo_q < count_q;
        rd_addr     = lo_q[IdxW-1:0];
        res_found_d = 1'b0;
        res_index_d = '0;
      end
      esss_pkg::StFinalCmp: begin
        res_found_d = (rd_data_q == query_q);
        res_index_d = (rd_data_q == query_q) ? lo_q : '0;
      end
      esss_pkg::StResult: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Key RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= key_biased;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    query_q     <= query_d;
    res_found_q <= res_found_d;
    res_index_q <= res_index_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esss_pkg::StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response register: load a finished word, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= res_found_q;
      out_index_q <= esss_pkg::MatchW'(res_index_q);
    end
  end

  // Checks
  `ESSS_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= Depth)
  `ESSS_ASSERT_SAME(a_read_in_range, clk_i, rst_ni, rd_en, rd_addr < count_q)
  `ESSS_ASSERT_SAME(a_bracket_order, clk_i, rst_ni, state_q == esss_pkg::StBin, lo_q <= hi_q)
  `ESSS_ASSERT_NEXT(a_result_from_seq, clk_i, rst_ni, out_load, out_valid_q)

endmodule
